// ===== rtl/image_fit_rectangles_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Image fit rectangles: assertion macros
// Shared property forms for the checker of the fit rectangles unit.
// ----------------------------------------------------------------------------
`ifndef IMAGE_FIT_RECTANGLES_UNIT_DEFINES_SVH
`define IMAGE_FIT_RECTANGLES_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FITR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FITR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define FITR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fitr_pkg.sv =====
// ----------------------------------------------------------------------------
// Image fit rectangles: package
// Widths, codes and word types shared by the fit rectangles pipeline.
// ----------------------------------------------------------------------------
package fitr_pkg;

  localparam int DIM_BITS       = 14;
  localparam int PROD_BITS      = 2 * DIM_BITS;
  localparam int DIV_STEP_BITS  = 2;
  localparam int DIV_STAGES     = (DIM_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef enum logic [1:0] {
    MODE_CENTER    = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_LETTERBOX = 2'd2,
    MODE_FILL      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    TGT_DST_H = 2'd0,
    TGT_DST_W = 2'd1,
    TGT_SRC_H = 2'd2,
    TGT_SRC_W = 2'd3
  } tgt_t;

  typedef struct packed {
    mode_t mode;
    dim_t  img_w;
    dim_t  img_h;
    dim_t  out_w;
    dim_t  out_h;
  } req_t;

  typedef struct packed {
    dim_t src_x;
    dim_t src_y;
    dim_t src_w;
    dim_t src_h;
    dim_t dst_x;
    dim_t dst_y;
    dim_t dst_w;
    dim_t dst_h;
  } rect_t;

  typedef struct packed {
    logic  use_div;
    tgt_t  tgt;
    dim_t  span;
    rect_t rect;
  } meta_t;

endpackage

// ===== rtl/image_fit_rectangles_unit.sv =====
// ----------------------------------------------------------------------------
// Image fit rectangles unit
// For a fit mode, an image size and an output size, returns the crop
// rectangle within the image and the drawn rectangle within the output.
//
// The request word enters on the in_ channel and the result word leaves on
// the out_ channel; a word moves when valid is high and stall is low. Every
// request gives exactly one result, in order. Modes are centered, scaled,
// zoomed letterbox and zoomed fill; the aspect test is an exact compare of
// cross products and scaled lengths are floor quotients.
// Registers in order: the cross products, the compare and select, one
// divider stage per two quotient bits, and the output register. A new
// request is taken every cycle while in_stall is low. When the receiver
// stalls, the pipeline keeps filling its empty stages and in_stall rises
// only once every stage holds a word.
// Reset clears all valid flags; no word is in flight after it.
// ----------------------------------------------------------------------------
module image_fit_rectangles_unit import fitr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_fit_mode,
  input  logic [DIM_BITS-1:0] in_image_width,
  input  logic [DIM_BITS-1:0] in_image_height,
  input  logic [DIM_BITS-1:0] in_output_width,
  input  logic [DIM_BITS-1:0] in_output_height,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DIM_BITS-1:0] out_source_x,
  output logic [DIM_BITS-1:0] out_source_y,
  output logic [DIM_BITS-1:0] out_source_width,
  output logic [DIM_BITS-1:0] out_source_height,
  output logic [DIM_BITS-1:0] out_dest_x,
  output logic [DIM_BITS-1:0] out_dest_y,
  output logic [DIM_BITS-1:0] out_dest_width,
  output logic [DIM_BITS-1:0] out_dest_height
);

  req_t  req;
  logic  prep_ready;
  logic  prep_valid;
  meta_t prep_meta;
  prod_t prep_num;
  dim_t  prep_den;
  logic  div_ready;
  logic  div_valid;
  meta_t div_meta;
  dim_t  div_quo;
  logic  res_ready;
  rect_t res_rect;

  assign req.mode  = mode_t'(in_fit_mode);
  assign req.img_w = in_image_width;
  assign req.img_h = in_image_height;
  assign req.out_w = in_output_width;
  assign req.out_h = in_output_height;

  fitr_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .up_req   (req),
    .dn_valid (prep_valid),
    .dn_ready (div_ready),
    .dn_meta  (prep_meta),
    .dn_num   (prep_num),
    .dn_den   (prep_den)
  );

  fitr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (div_ready),
    .up_meta  (prep_meta),
    .up_num   (prep_num),
    .up_den   (prep_den),
    .dn_valid (div_valid),
    .dn_ready (res_ready),
    .dn_meta  (div_meta),
    .dn_quo   (div_quo)
  );

  fitr_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (div_valid),
    .up_ready (res_ready),
    .up_meta  (div_meta),
    .up_quo   (div_quo),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_rect  (res_rect)
  );

  assign in_stall          = !prep_ready;
  assign out_source_x      = res_rect.src_x;
  assign out_source_y      = res_rect.src_y;
  assign out_source_width  = res_rect.src_w;
  assign out_source_height = res_rect.src_h;
  assign out_dest_x        = res_rect.dst_x;
  assign out_dest_y        = res_rect.dst_y;
  assign out_dest_width    = res_rect.dst_w;
  assign out_dest_height   = res_rect.dst_h;

endmodule

// ===== rtl/fitr_prep.sv =====
// ----------------------------------------------------------------------------
// Image fit rectangles: front stages
// Forms the two cross products, then compares them and picks the dividend,
// the divisor and the fixed fields of the result.
// ----------------------------------------------------------------------------
module fitr_prep import fitr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  req_t  up_req,
  output logic  dn_valid,
  input  logic  dn_ready,
  output meta_t dn_meta,
  output prod_t dn_num,
  output dim_t  dn_den
);

  typedef struct packed {
    dim_t src_off;
    dim_t len;
    dim_t dst_off;
  } center_t;

  function automatic center_t center_axis(dim_t img_len, dim_t out_len);
    center_t c;
    if (out_len >= img_len) begin
      c.src_off = '0;
      c.len     = img_len;
      c.dst_off = dim_t'((out_len - img_len) >> 1);
    end else begin
      c.dst_off = '0;
      c.len     = out_len;
      c.src_off = dim_t'((img_len - out_len) >> 1);
    end
    return c;
  endfunction

  logic    a_valid_r;
  req_t    a_req_r;
  prod_t   a_lhs_r;
  prod_t   a_rhs_r;
  logic    b_valid_r;
  meta_t   b_meta_r;
  prod_t   b_num_r;
  dim_t    b_den_r;
  logic    a_ready;
  logic    b_ready;
  meta_t   meta_nxt;
  prod_t   num_nxt;
  dim_t    den_nxt;
  center_t cx;
  center_t cy;

  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_req_r <= up_req;
      a_lhs_r <= PROD_BITS'(up_req.out_w) * PROD_BITS'(up_req.img_h);
      a_rhs_r <= PROD_BITS'(up_req.out_h) * PROD_BITS'(up_req.img_w);
    end
    if (b_ready && a_valid_r) begin
      b_meta_r <= meta_nxt;
      b_num_r  <= num_nxt;
      b_den_r  <= den_nxt;
    end
  end

  always_comb begin
    meta_nxt = '0;
    num_nxt  = a_lhs_r;
    den_nxt  = a_req_r.img_w;
    cx       = center_axis(a_req_r.img_w, a_req_r.out_w);
    cy       = center_axis(a_req_r.img_h, a_req_r.out_h);
    case (a_req_r.mode)
      MODE_CENTER: begin
        meta_nxt.rect.src_x = cx.src_off;
        meta_nxt.rect.src_w = cx.len;
        meta_nxt.rect.dst_x = cx.dst_off;
        meta_nxt.rect.dst_w = cx.len;
        meta_nxt.rect.src_y = cy.src_off;
        meta_nxt.rect.src_h = cy.len;
        meta_nxt.rect.dst_y = cy.dst_off;
        meta_nxt.rect.dst_h = cy.len;
      end
      MODE_SCALE: begin
        meta_nxt.rect.src_w = a_req_r.img_w;
        meta_nxt.rect.src_h = a_req_r.img_h;
        meta_nxt.rect.dst_w = a_req_r.out_w;
        meta_nxt.rect.dst_h = a_req_r.out_h;
      end
      MODE_LETTERBOX: begin
        meta_nxt.use_div    = 1'b1;
        meta_nxt.rect.src_w = a_req_r.img_w;
        meta_nxt.rect.src_h = a_req_r.img_h;
        if (a_lhs_r < a_rhs_r) begin
          meta_nxt.rect.dst_w = a_req_r.out_w;
          meta_nxt.tgt        = TGT_DST_H;
          meta_nxt.span       = a_req_r.out_h;
          num_nxt             = a_lhs_r;
          den_nxt             = a_req_r.img_w;
        end else begin
          meta_nxt.rect.dst_h = a_req_r.out_h;
          meta_nxt.tgt        = TGT_DST_W;
          meta_nxt.span       = a_req_r.out_w;
          num_nxt             = a_rhs_r;
          den_nxt             = a_req_r.img_h;
        end
      end
      MODE_FILL: begin
        meta_nxt.use_div    = 1'b1;
        meta_nxt.rect.dst_w = a_req_r.out_w;
        meta_nxt.rect.dst_h = a_req_r.out_h;
        if (a_lhs_r > a_rhs_r) begin
          meta_nxt.rect.src_w = a_req_r.img_w;
          meta_nxt.tgt        = TGT_SRC_H;
          meta_nxt.span       = a_req_r.img_h;
          num_nxt             = a_rhs_r;
          den_nxt             = a_req_r.out_w;
        end else begin
          meta_nxt.rect.src_h = a_req_r.img_h;
          meta_nxt.tgt        = TGT_SRC_W;
          meta_nxt.span       = a_req_r.img_w;
          num_nxt             = a_lhs_r;
          den_nxt             = a_req_r.out_h;
        end
      end
      default: begin
        meta_nxt = '0;
      end
    endcase
    // A zero divisor yields a zero quotient.
    if (den_nxt == '0) begin
      num_nxt = '0;
      den_nxt = dim_t'(1);
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_meta  = b_meta_r;
  assign dn_num   = b_num_r;
  assign dn_den   = b_den_r;

endmodule

// ===== rtl/fitr_div.sv =====
// ----------------------------------------------------------------------------
// Image fit rectangles: pipelined divider
// Restoring division of a product by a length, two quotient bits per stage.
// The quotient is known to fit in one dimension word.
// ----------------------------------------------------------------------------
module fitr_div import fitr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  meta_t up_meta,
  input  prod_t up_num,
  input  dim_t  up_den,
  output logic  dn_valid,
  input  logic  dn_ready,
  output meta_t dn_meta,
  output dim_t  dn_quo
);

  logic  v_r    [DIV_STAGES];
  meta_t meta_r [DIV_STAGES];
  dim_t  den_r  [DIV_STAGES];
  dim_t  rem_r  [DIV_STAGES];
  dim_t  work_r [DIV_STAGES];
  logic  rdy    [DIV_STAGES+1];

  assign rdy[DIV_STAGES] = dn_ready;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic  in_v;
    meta_t in_meta;
    dim_t  in_den;
    dim_t  in_rem;
    dim_t  in_work;
    dim_t  rem_nxt;
    dim_t  work_nxt;

    if (s == 0) begin : g_first
      assign in_v    = up_valid;
      assign in_meta = up_meta;
      assign in_den  = up_den;
      assign in_rem  = up_num[PROD_BITS-1:DIM_BITS];
      assign in_work = up_num[DIM_BITS-1:0];
    end else begin : g_next
      assign in_v    = v_r[s-1];
      assign in_meta = meta_r[s-1];
      assign in_den  = den_r[s-1];
      assign in_rem  = rem_r[s-1];
      assign in_work = work_r[s-1];
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_comb begin
      logic [DIM_BITS:0] t;
      logic              q_bit;
      t        = '0;
      q_bit    = 1'b0;
      rem_nxt  = in_rem;
      work_nxt = in_work;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
        if (s * DIV_STEP_BITS + k < DIM_BITS) begin
          t = {rem_nxt, work_nxt[DIM_BITS-1]};
          if (t >= {1'b0, in_den}) begin
            rem_nxt = dim_t'(t - {1'b0, in_den});
            q_bit   = 1'b1;
          end else begin
            rem_nxt = t[DIM_BITS-1:0];
            q_bit   = 1'b0;
          end
          work_nxt = {work_nxt[DIM_BITS-2:0], q_bit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s+1] || !v_r[s]) begin
        v_r[s] <= in_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && in_v) begin
        meta_r[s] <= in_meta;
        den_r[s]  <= in_den;
        rem_r[s]  <= rem_nxt;
        work_r[s] <= work_nxt;
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[DIV_STAGES-1];
  assign dn_meta  = meta_r[DIV_STAGES-1];
  assign dn_quo   = work_r[DIV_STAGES-1];

endmodule

// ===== rtl/fitr_out.sv =====
// ----------------------------------------------------------------------------
// Image fit rectangles: result stage
// Places the quotient and its centering offset into the result word and
// holds the word in the output register until it is taken.
// ----------------------------------------------------------------------------
module fitr_out import fitr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  meta_t up_meta,
  input  dim_t  up_quo,
  output logic  dn_valid,
  input  logic  dn_stall,
  output rect_t dn_rect
);

  logic  out_valid_r;
  rect_t out_rect_r;
  rect_t rect_nxt;
  dim_t  off;

  assign up_ready = !out_valid_r || !dn_stall;

  always_comb begin
    rect_nxt = up_meta.rect;
    off      = dim_t'((up_meta.span - up_quo) >> 1);
    if (up_meta.use_div) begin
      case (up_meta.tgt)
        TGT_DST_H: begin
          rect_nxt.dst_h = up_quo;
          rect_nxt.dst_y = off;
        end
        TGT_DST_W: begin
          rect_nxt.dst_w = up_quo;
          rect_nxt.dst_x = off;
        end
        TGT_SRC_H: begin
          rect_nxt.src_h = up_quo;
          rect_nxt.src_y = off;
        end
        TGT_SRC_W: begin
          rect_nxt.src_w = up_quo;
          rect_nxt.src_x = off;
        end
        default: begin
          rect_nxt = up_meta.rect;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      out_rect_r <= rect_nxt;
    end
  end

  assign dn_valid = out_valid_r;
  assign dn_rect  = out_rect_r;

endmodule

// ===== rtl/fitr_checker.sv =====
// ----------------------------------------------------------------------------
// Image fit rectangles: port checker
// Watches the ports of the unit for flow control and reset behavior.
// ----------------------------------------------------------------------------
`include "image_fit_rectangles_unit_defines.svh"

module fitr_checker import fitr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [1:0]          in_fit_mode,
  input logic [DIM_BITS-1:0] in_image_width,
  input logic [DIM_BITS-1:0] in_image_height,
  input logic [DIM_BITS-1:0] in_output_width,
  input logic [DIM_BITS-1:0] in_output_height,
  input logic                out_valid,
  input logic                out_stall,
  input logic [DIM_BITS-1:0] out_source_x,
  input logic [DIM_BITS-1:0] out_source_y,
  input logic [DIM_BITS-1:0] out_source_width,
  input logic [DIM_BITS-1:0] out_source_height,
  input logic [DIM_BITS-1:0] out_dest_x,
  input logic [DIM_BITS-1:0] out_dest_y,
  input logic [DIM_BITS-1:0] out_dest_width,
  input logic [DIM_BITS-1:0] out_dest_height
);

  logic [4*DIM_BITS+1:0] in_word;
  logic [8*DIM_BITS-1:0] out_word;

  assign in_word  = {in_fit_mode, in_image_width, in_image_height,
                     in_output_width, in_output_height};
  assign out_word = {out_source_x, out_source_y, out_source_width, out_source_height,
                     out_dest_x, out_dest_y, out_dest_width, out_dest_height};

  // A stalled request word stays offered and unchanged.
  `FITR_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word),
                   "request word changed while stalled")

  // A held result word keeps its value until it is taken.
  `FITR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word),
                   "result word changed while stalled")

  // The input backs up only when a result word is waiting at a stalled output.
  `FITR_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
                   "input stalled with the output free")

  // Reset leaves no result word in flight.
  `FITR_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result word valid after reset")

endmodule

bind image_fit_rectangles_unit fitr_checker u_fitr_checker (.*);

// ===== test/image_fit_rectangles_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image fit rectangles unit: testbench
// Sends requests in all four fit modes, first a directed set of corner
// cases and then random requests. Each accepted request is predicted here
// and the result words are checked field by field in arrival order, while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import fitr_pkg::*;

  localparam int DIM_MAX      = (1 << DIM_BITS) - 1;
  localparam int RANDOM_WORDS = 850;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 30;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    req_t req;
    bit   drain_first;
  } pending_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_fit_mode = '0;
  logic [DIM_BITS-1:0] in_image_width = '0;
  logic [DIM_BITS-1:0] in_image_height = '0;
  logic [DIM_BITS-1:0] in_output_width = '0;
  logic [DIM_BITS-1:0] in_output_height = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DIM_BITS-1:0] out_source_x;
  logic [DIM_BITS-1:0] out_source_y;
  logic [DIM_BITS-1:0] out_source_width;
  logic [DIM_BITS-1:0] out_source_height;
  logic [DIM_BITS-1:0] out_dest_x;
  logic [DIM_BITS-1:0] out_dest_y;
  logic [DIM_BITS-1:0] out_dest_width;
  logic [DIM_BITS-1:0] out_dest_height;

  pending_word_t pending_words[$];
  rect_t         rect_expected[$];
  bit            req_accepted = 1'b0;
  bit            rsp_accepted = 1'b0;
  bit            calm_sender = 1'b0;
  bit            calm_receiver = 1'b0;
  bit            hold_done = 1'b0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            hold_left = 0;
  int            words_offered = 0;
  int            requests_taken = 0;
  int            results_seen = 0;
  int            total_words = 0;
  int            fail_count = 0;
  int            cycle_count = 0;

  image_fit_rectangles_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_fit_mode       (in_fit_mode),
    .in_image_width    (in_image_width),
    .in_image_height   (in_image_height),
    .in_output_width   (in_output_width),
    .in_output_height  (in_output_height),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_source_x      (out_source_x),
    .out_source_y      (out_source_y),
    .out_source_width  (out_source_width),
    .out_source_height (out_source_height),
    .out_dest_x        (out_dest_x),
    .out_dest_y        (out_dest_y),
    .out_dest_width    (out_dest_width),
    .out_dest_height   (out_dest_height)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic longint unsigned floor_quot(longint unsigned num, longint unsigned den);
    return (den == 0) ? 0 : num / den;
  endfunction

  function automatic rect_t fit_rects(req_t r);
    longint unsigned iw, ih, ow, oh, lhs, rhs;
    longint unsigned sx, sy, sw, sh, dx, dy, dw, dh;
    rect_t res;
    iw = r.img_w;
    ih = r.img_h;
    ow = r.out_w;
    oh = r.out_h;
    lhs = ow * ih;
    rhs = oh * iw;
    sx = 0; sy = 0; sw = 0; sh = 0;
    dx = 0; dy = 0; dw = 0; dh = 0;
    case (r.mode)
      MODE_CENTER: begin
        if (ow >= iw) begin
          sw = iw;
          dx = (ow - iw) >> 1;
        end else begin
          sw = ow;
          sx = (iw - ow) >> 1;
        end
        if (oh >= ih) begin
          sh = ih;
          dy = (oh - ih) >> 1;
        end else begin
          sh = oh;
          sy = (ih - oh) >> 1;
        end
        dw = sw;
        dh = sh;
      end
      MODE_SCALE: begin
        sw = iw;
        sh = ih;
        dw = ow;
        dh = oh;
      end
      MODE_LETTERBOX: begin
        sw = iw;
        sh = ih;
        if (lhs < rhs) begin
          dw = ow;
          dh = floor_quot(ih * ow, iw);
          dy = (oh - dh) >> 1;
        end else begin
          dh = oh;
          dw = floor_quot(iw * oh, ih);
          dx = (ow - dw) >> 1;
        end
      end
      default: begin
        dw = ow;
        dh = oh;
        if (lhs > rhs) begin
          sw = iw;
          sh = floor_quot(oh * iw, ow);
          sy = (ih - sh) >> 1;
        end else begin
          sh = ih;
          sw = floor_quot(ow * ih, oh);
          sx = (iw - sw) >> 1;
        end
      end
    endcase
    res.src_x = dim_t'(sx);
    res.src_y = dim_t'(sy);
    res.src_w = dim_t'(sw);
    res.src_h = dim_t'(sh);
    res.dst_x = dim_t'(dx);
    res.dst_y = dim_t'(dy);
    res.dst_w = dim_t'(dw);
    res.dst_h = dim_t'(dh);
    return res;
  endfunction

  function automatic dim_t near_dim(dim_t v);
    int t;
    t = int'(v) + int'($urandom_range(0, 16)) - 8;
    if (t < 0) t = 0;
    if (t > DIM_MAX) t = DIM_MAX;
    return dim_t'(t);
  endfunction

  function automatic req_t random_req();
    req_t r;
    int unsigned kind, a, b, m1, m2, top, zero_mask;
    kind = $urandom_range(0, 99);
    r.mode = mode_t'($urandom_range(0, 3));
    r.img_w = dim_t'($urandom);
    r.img_h = dim_t'($urandom);
    r.out_w = dim_t'($urandom);
    r.out_h = dim_t'($urandom);
    if (kind >= 40 && kind < 60) begin
      r.img_w = dim_t'($urandom_range(1, 64));
      r.img_h = dim_t'($urandom_range(1, 64));
      r.out_w = dim_t'($urandom_range(1, 64));
      r.out_h = dim_t'($urandom_range(1, 64));
    end else if (kind >= 60 && kind < 75) begin
      // Equal aspect ratios, so the cross products tie.
      a = $urandom_range(1, 40);
      b = $urandom_range(1, 40);
      top = (a > b) ? a : b;
      m1 = $urandom_range(1, DIM_MAX / top);
      m2 = $urandom_range(1, DIM_MAX / top);
      r.img_w = dim_t'(a * m1);
      r.img_h = dim_t'(b * m1);
      r.out_w = dim_t'(a * m2);
      r.out_h = dim_t'(b * m2);
    end else if (kind >= 75 && kind < 90) begin
      r.out_w = near_dim(r.img_w);
      r.out_h = near_dim(r.img_h);
    end else if (kind >= 90) begin
      zero_mask = $urandom_range(1, 15);
      if (zero_mask[0]) r.img_w = '0;
      if (zero_mask[1]) r.img_h = '0;
      if (zero_mask[2]) r.out_w = '0;
      if (zero_mask[3]) r.out_h = '0;
    end
    return r;
  endfunction

  task automatic queue_word(mode_t mode, int iw, int ih, int ow, int oh, bit drain);
    pending_word_t w;
    w.req.mode = mode;
    w.req.img_w = dim_t'(iw);
    w.req.img_h = dim_t'(ih);
    w.req.out_w = dim_t'(ow);
    w.req.out_h = dim_t'(oh);
    w.drain_first = drain;
    pending_words.push_back(w);
  endtask

  task automatic compare_field(string field, dim_t want, dim_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Driver.
  always @(negedge clk) begin
    pending_word_t w;
    if (rst_n) begin
      if (!in_valid || req_accepted) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain_first && rect_expected.size() != 0)) begin
          w = pending_words.pop_front();
          in_fit_mode <= w.req.mode;
          in_image_width <= w.req.img_w;
          in_image_height <= w.req.img_h;
          in_output_width <= w.req.out_w;
          in_output_height <= w.req.out_h;
          in_valid <= 1'b1;
          words_offered++;
          if (words_offered % 40 == 0) calm_sender = ($urandom_range(0, 3) == 0);
          send_gap <= calm_sender ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    int unsigned n;
    if (rst_n) begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rsp_accepted) begin
        if (results_seen % 40 == 0) calm_receiver = ($urandom_range(0, 3) == 0);
        n = calm_receiver ? 0 : $urandom_range(0, 9);
        out_stall <= (n != 0);
        stall_left = (n != 0) ? n - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    req_t  seen_req;
    rect_t want;
    req_accepted <= rst_n && in_valid && !in_stall;
    rsp_accepted <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (rect_expected.size() == 0) begin
        $error("result word arrived with no request outstanding");
        fail_count++;
      end else begin
        want = rect_expected.pop_front();
        compare_field("source_x", want.src_x, out_source_x);
        compare_field("source_y", want.src_y, out_source_y);
        compare_field("source_width", want.src_w, out_source_width);
        compare_field("source_height", want.src_h, out_source_height);
        compare_field("dest_x", want.dst_x, out_dest_x);
        compare_field("dest_y", want.dst_y, out_dest_y);
        compare_field("dest_width", want.dst_w, out_dest_width);
        compare_field("dest_height", want.dst_h, out_dest_height);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      seen_req.mode = mode_t'(in_fit_mode);
      seen_req.img_w = in_image_width;
      seen_req.img_h = in_image_height;
      seen_req.out_w = in_output_width;
      seen_req.out_h = in_output_height;
      rect_expected.push_back(fit_rects(seen_req));
      requests_taken++;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("image_fit_rectangles_unit: mismatch");
    $finish;
  end

  initial begin
    pending_word_t w;
    queue_word(MODE_CENTER, 100, 50, 100, 50, 1'b0);
    queue_word(MODE_CENTER, DIM_MAX, 1, 1, DIM_MAX, 1'b0);
    queue_word(MODE_CENTER, 1, DIM_MAX, DIM_MAX, 1, 1'b0);
    queue_word(MODE_CENTER, 101, 7, 40, 10, 1'b0);
    queue_word(MODE_CENTER, 0, 0, DIM_MAX, 0, 1'b0);
    queue_word(MODE_SCALE, DIM_MAX, DIM_MAX, 1, 1, 1'b0);
    queue_word(MODE_SCALE, 0, 1, DIM_MAX, 0, 1'b0);
    queue_word(MODE_LETTERBOX, 1920, 1080, 1280, 1024, 1'b0);
    queue_word(MODE_LETTERBOX, 1080, 1920, 1920, 1080, 1'b0);
    queue_word(MODE_LETTERBOX, 640, 480, 320, 240, 1'b0);
    queue_word(MODE_LETTERBOX, DIM_MAX, 1, 1, DIM_MAX, 1'b0);
    queue_word(MODE_LETTERBOX, 1, DIM_MAX, DIM_MAX, 1, 1'b0);
    queue_word(MODE_LETTERBOX, 0, 5, 7, 9, 1'b0);
    queue_word(MODE_LETTERBOX, 0, 0, 5, 5, 1'b0);
    queue_word(MODE_LETTERBOX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 1'b0);
    queue_word(MODE_FILL, 1920, 1080, 1080, 1920, 1'b0);
    queue_word(MODE_FILL, 1080, 1920, 1920, 1080, 1'b0);
    queue_word(MODE_FILL, 640, 480, 320, 240, 1'b0);
    queue_word(MODE_FILL, DIM_MAX, DIM_MAX, 1, DIM_MAX, 1'b0);
    queue_word(MODE_FILL, DIM_MAX, 1, DIM_MAX, DIM_MAX, 1'b0);
    queue_word(MODE_FILL, 7, 9, 0, 5, 1'b0);
    queue_word(MODE_FILL, 0, 0, 0, 0, 1'b0);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      w.req = random_req();
      w.drain_first = (i == 0) || (i == RANDOM_WORDS / 2);
      pending_words.push_back(w);
    end
    total_words = pending_words.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (requests_taken != total_words) @(negedge clk);
    while (rect_expected.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("image_fit_rectangles_unit: match");
    end else begin
      $display("image_fit_rectangles_unit: mismatch");
    end
    $finish;
  end

endmodule
